@@ sv/cusum_pkg.sv @@
// Shared types and constants for the two-sided CUSUM change detector.
package cusum_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned ALLOW_W  = 15;
  localparam int unsigned SUM_W    = 24;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic signed [SAMPLE_W-1:0] REF_MEAN_RST       = '0;
  localparam logic [ALLOW_W-1:0]         ALLOWANCE_RST      = ALLOW_W'(128);
  localparam logic [SUM_W-1:0]           THRESHOLD_RST      = SUM_W'(1280);
  localparam logic                       CLEAR_ON_ALARM_RST = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF_MEAN       = 2'd0,
    CFG_ALLOWANCE      = 2'd1,
    CFG_THRESHOLD      = 2'd2,
    CFG_CLEAR_ON_ALARM = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_CLEAR  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [SUM_W-1:0] pos_sum;
    logic [SUM_W-1:0] neg_sum;
    logic             up_fire;
    logic             down_fire;
    logic [SUM_W-1:0] up_value;
    logic [SUM_W-1:0] down_value;
    logic             alarmed;
    logic [CNT_W-1:0] up_count;
    logic [CNT_W-1:0] down_count;
    logic [CNT_W-1:0] sample_count;
  } cusum_res_t;

  function automatic logic [CNT_W-1:0] cnt_bump(input logic [CNT_W-1:0] c);
    cnt_bump = (c == CNT_MAX) ? c : c + CNT_W'(1);
  endfunction

  // Add an 18-bit signed step to a sum, clamp at zero and saturate at the top.
  function automatic logic [SUM_W-1:0] sum_step(input logic [SUM_W-1:0]  s,
                                                input logic signed [17:0] d);
    logic signed [SUM_W+1:0] r;
    r = $signed({2'b00, s}) + (SUM_W+2)'(d);
    if (r < 0) begin
      sum_step = '0;
    end else if (r > $signed({2'b00, SUM_MAX})) begin
      sum_step = SUM_MAX;
    end else begin
      sum_step = r[SUM_W-1:0];
    end
  endfunction

endpackage

@@ sv/cusum_if.sv @@
// Valid/ready channel interfaces for samples in and results out.
interface cusum_in_if import cusum_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output kind, output sample, input ready);
  modport sink   (input valid, input kind, input sample, output ready);
endinterface

interface cusum_out_if import cusum_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] pos_sum;
  logic [SUM_W-1:0] neg_sum;
  logic             up_fire;
  logic             down_fire;
  logic [SUM_W-1:0] up_value;
  logic [SUM_W-1:0] down_value;
  logic             alarmed;
  logic [CNT_W-1:0] up_count;
  logic [CNT_W-1:0] down_count;
  logic [CNT_W-1:0] sample_count;

  modport source (output valid, output pos_sum, output neg_sum, output up_fire,
                  output down_fire, output up_value, output down_value,
                  output alarmed, output up_count, output down_count,
                  output sample_count, input ready);
  modport sink   (input valid, input pos_sum, input neg_sum, input up_fire,
                  input down_fire, input up_value, input down_value,
                  input alarmed, input up_count, input down_count,
                  input sample_count, output ready);
endinterface

@@ sv/two_sided_cusum_detector_core.sv @@
// Two-sided CUSUM change detector: upper and lower sums, alarms, saturating totals.
//
// Each accepted transaction is a signed Q8.8 sample or a clear command. The
// sums, alarms and totals are updated in the cycle of acceptance and the
// result is registered in the result register, or in the skid register while
// the result register is held, so one transaction is taken every cycle while
// the skid register is empty. The add, clamp and threshold compare are combinational.
// A two-entry output stage (result register plus skid register) lets input
// keep flowing while a result waits; input stalls only when both are full.
// Any write to a configuration register zeroes the sums and totals.
module two_sided_cusum_detector_core
  import cusum_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  cusum_in_if.sink             in_i,
  cusum_out_if.source          out_o
);

  logic signed [SAMPLE_W-1:0] ref_mean_q;
  logic [ALLOW_W-1:0]         allowance_q;
  logic [SUM_W-1:0]           threshold_q;
  logic                       clear_on_alarm_q;

  logic [SUM_W-1:0] upper_q, upper_d;
  logic [SUM_W-1:0] lower_q, lower_d;
  logic [CNT_W-1:0] up_cnt_q, up_cnt_d;
  logic [CNT_W-1:0] dn_cnt_q, dn_cnt_d;
  logic [CNT_W-1:0] smp_cnt_q, smp_cnt_d;

  cusum_res_t res_d, out_q, skid_q;
  logic       out_valid_q, skid_valid_q;

  logic                       in_fire, out_fire;
  logic signed [SAMPLE_W:0]   dev;
  logic signed [17:0]         up_step, dn_step;
  logic [SUM_W-1:0]           upper_new, lower_new;
  logic                       up_fire, dn_fire, any_fire;

  assign in_i.ready = !skid_valid_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_valid_q && out_o.ready;

  always_comb begin
    dev       = $signed({in_i.sample[SAMPLE_W-1], in_i.sample})
              - $signed({ref_mean_q[SAMPLE_W-1], ref_mean_q});
    up_step   = 18'(dev) - $signed({3'b000, allowance_q});
    dn_step   = -18'(dev) - $signed({3'b000, allowance_q});
    upper_new = sum_step(upper_q, up_step);
    lower_new = sum_step(lower_q, dn_step);
    up_fire   = upper_new > threshold_q;
    // an upward alarm with clear-on-alarm clears the lower sum first
    dn_fire   = (lower_new > threshold_q) && !(clear_on_alarm_q && up_fire);
    any_fire  = up_fire || dn_fire;

    upper_d   = (clear_on_alarm_q && any_fire) ? '0 : upper_new;
    lower_d   = (clear_on_alarm_q && any_fire) ? '0 : lower_new;
    up_cnt_d  = up_fire ? cnt_bump(up_cnt_q) : up_cnt_q;
    dn_cnt_d  = dn_fire ? cnt_bump(dn_cnt_q) : dn_cnt_q;
    smp_cnt_d = cnt_bump(smp_cnt_q);

    res_d = '0;
    if (in_i.kind == KIND_SAMPLE) begin
      res_d.pos_sum      = upper_d;
      res_d.neg_sum      = lower_d;
      res_d.up_fire      = up_fire;
      res_d.down_fire    = dn_fire;
      res_d.up_value     = up_fire ? upper_new : '0;
      res_d.down_value   = dn_fire ? lower_new : '0;
      res_d.alarmed      = any_fire || (upper_d > threshold_q) || (lower_d > threshold_q);
      res_d.up_count     = up_cnt_d;
      res_d.down_count   = dn_cnt_d;
      res_d.sample_count = smp_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_mean_q       <= REF_MEAN_RST;
      allowance_q      <= ALLOWANCE_RST;
      threshold_q      <= THRESHOLD_RST;
      clear_on_alarm_q <= CLEAR_ON_ALARM_RST;
      upper_q          <= '0;
      lower_q          <= '0;
      up_cnt_q         <= '0;
      dn_cnt_q         <= '0;
      smp_cnt_q        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_REF_MEAN:       ref_mean_q       <= $signed(cfg_data_i[SAMPLE_W-1:0]);
        CFG_ALLOWANCE:      allowance_q      <= cfg_data_i[ALLOW_W-1:0];
        CFG_THRESHOLD:      threshold_q      <= cfg_data_i[SUM_W-1:0];
        CFG_CLEAR_ON_ALARM: clear_on_alarm_q <= cfg_data_i[0];
        default:            ;
      endcase
      upper_q   <= '0;
      lower_q   <= '0;
      up_cnt_q  <= '0;
      dn_cnt_q  <= '0;
      smp_cnt_q <= '0;
    end else if (in_fire) begin
      if (in_i.kind == KIND_CLEAR) begin
        upper_q   <= '0;
        lower_q   <= '0;
        up_cnt_q  <= '0;
        dn_cnt_q  <= '0;
        smp_cnt_q <= '0;
      end else begin
        upper_q   <= upper_d;
        lower_q   <= lower_d;
        up_cnt_q  <= up_cnt_d;
        dn_cnt_q  <= dn_cnt_d;
        smp_cnt_q <= smp_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_o.ready) begin
        skid_valid_q <= 1'b1;
      end
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_o.ready) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pos_sum      = out_q.pos_sum;
  assign out_o.neg_sum      = out_q.neg_sum;
  assign out_o.up_fire      = out_q.up_fire;
  assign out_o.down_fire    = out_q.down_fire;
  assign out_o.up_value     = out_q.up_value;
  assign out_o.down_value   = out_q.down_value;
  assign out_o.alarmed      = out_q.alarmed;
  assign out_o.up_count     = out_q.up_count;
  assign out_o.down_count   = out_q.down_count;
  assign out_o.sample_count = out_q.sample_count;

endmodule

@@ dv/two_sided_cusum_detector_core_test.sv @@
// Self-checking testbench for the two-sided CUSUM change detector core.
`timescale 1ns / 1ps

module two_sided_cusum_detector_core_test;
  import cusum_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;

  class cusum_scoreboard;
    logic signed [SAMPLE_W-1:0] ref_mean;
    logic [ALLOW_W-1:0]         allowance;
    logic [SUM_W-1:0]           threshold;
    logic                       clear_on_alarm;
    logic [SUM_W-1:0]           upper_sum;
    logic [SUM_W-1:0]           lower_sum;
    logic                       alarm_flag;
    logic [CNT_W-1:0]           up_total;
    logic [CNT_W-1:0]           down_total;
    logic [CNT_W-1:0]           samples_seen;
    cusum_res_t                 expected_q[$];
    int unsigned                errors;

    function new();
      ref_mean       = REF_MEAN_RST;
      allowance      = ALLOWANCE_RST;
      threshold      = THRESHOLD_RST;
      clear_on_alarm = CLEAR_ON_ALARM_RST;
      errors         = 0;
      zero_state();
    endfunction

    function void zero_state();
      upper_sum    = '0;
      lower_sum    = '0;
      alarm_flag   = 1'b0;
      up_total     = '0;
      down_total   = '0;
      samples_seen = '0;
    endfunction

    function void set_register(cfg_idx_e idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_REF_MEAN:       ref_mean       = data[SAMPLE_W-1:0];
        CFG_ALLOWANCE:      allowance      = data[ALLOW_W-1:0];
        CFG_THRESHOLD:      threshold      = data[SUM_W-1:0];
        CFG_CLEAR_ON_ALARM: clear_on_alarm = data[0];
        default: ;
      endcase
      zero_state();
    endfunction

    function logic [SUM_W-1:0] clamp_add(logic [SUM_W-1:0] s, int d);
      int r;
      r = int'(s) + d;
      if (r < 0) return '0;
      if (r > int'(SUM_MAX)) return SUM_MAX;
      return r[SUM_W-1:0];
    endfunction

    function void note_input(kind_e kind, logic signed [SAMPLE_W-1:0] x);
      cusum_res_t r;
      int         dev;
      r = '0;
      if (kind == KIND_CLEAR) begin
        zero_state();
      end else begin
        dev = int'(x) - int'(ref_mean);
        if (samples_seen != CNT_MAX) samples_seen++;
        upper_sum = clamp_add(upper_sum, dev - int'(allowance));
        lower_sum = clamp_add(lower_sum, -dev - int'(allowance));
        // upward check first: its reset can suppress the downward alarm
        if (upper_sum > threshold) begin
          r.up_fire  = 1'b1;
          r.up_value = upper_sum;
          if (up_total != CNT_MAX) up_total++;
          if (clear_on_alarm) begin
            upper_sum = '0;
            lower_sum = '0;
          end
        end
        if (lower_sum > threshold) begin
          r.down_fire  = 1'b1;
          r.down_value = lower_sum;
          if (down_total != CNT_MAX) down_total++;
          if (clear_on_alarm) begin
            upper_sum = '0;
            lower_sum = '0;
          end
        end
        alarm_flag = r.up_fire | r.down_fire | (upper_sum > threshold) |
                     (lower_sum > threshold);
      end
      r.pos_sum      = upper_sum;
      r.neg_sum      = lower_sum;
      r.alarmed      = alarm_flag;
      r.up_count     = up_total;
      r.down_count   = down_total;
      r.sample_count = samples_seen;
      expected_q.push_back(r);
    endfunction

    function void check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] seen);
      if (want !== seen) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(cusum_res_t got);
      cusum_res_t want;
      if (expected_q.size() == 0) begin
        $error("result transaction with no expected result waiting");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      check_field("pos_sum", CNT_W'(want.pos_sum), CNT_W'(got.pos_sum));
      check_field("neg_sum", CNT_W'(want.neg_sum), CNT_W'(got.neg_sum));
      check_field("up_fire", CNT_W'(want.up_fire), CNT_W'(got.up_fire));
      check_field("down_fire", CNT_W'(want.down_fire), CNT_W'(got.down_fire));
      check_field("up_value", CNT_W'(want.up_value), CNT_W'(got.up_value));
      check_field("down_value", CNT_W'(want.down_value), CNT_W'(got.down_value));
      check_field("alarmed", CNT_W'(want.alarmed), CNT_W'(got.alarmed));
      check_field("up_count", want.up_count, got.up_count);
      check_field("down_count", want.down_count, got.down_count);
      check_field("sample_count", want.sample_count, got.sample_count);
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  cusum_in_if  in_ch ();
  cusum_out_if out_ch ();

  two_sided_cusum_detector_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  cusum_scoreboard sb = new();
  bit              gaps_on = 1'b1;
  int unsigned     quiet_cycles = 0;
  int              drift;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic int idle_len();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(4, 20));
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int unsigned r;
    int          v;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      v = $urandom_range(0, 1) ? 32767 : -32768;
    end else if (r < 50) begin
      v = int'($signed(16'($urandom)));
    end else begin
      v = int'(sb.ref_mean) + drift + int'($urandom_range(0, 512)) - 256;
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic push_item(kind_e kind, logic signed [SAMPLE_W-1:0] x);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.kind   <= kind;
    in_ch.sample <= x;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] data);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.set_register(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // stuff unused upper bits with junk so that truncation is exercised
  function automatic logic [CFG_W-1:0] junk_above(logic [CFG_W-1:0] v, int unsigned w);
    logic [CFG_W-1:0] mask;
    mask = (CFG_W'(1) << w) - CFG_W'(1);
    return (CFG_W'($urandom) & ~mask) | (v & mask);
  endfunction

  task automatic run_saturation(logic signed [SAMPLE_W-1:0] tgt, logic signed [SAMPLE_W-1:0] x);
    write_reg(CFG_REF_MEAN, junk_above(CFG_W'(tgt), SAMPLE_W));
    write_reg(CFG_ALLOWANCE, junk_above('0, ALLOW_W));
    write_reg(CFG_THRESHOLD, SUM_MAX);
    write_reg(CFG_CLEAR_ON_ALARM, junk_above('0, 1));
    repeat (280) begin
      if ($urandom_range(0, 9) != 0) push_item(KIND_SAMPLE, x);
      else push_item(KIND_SAMPLE, pick_sample());
    end
  endtask

  task automatic run_random_phase();
    logic [CFG_W-1:0] vals [4];
    int unsigned      start;
    cfg_idx_e         idx;
    case ($urandom_range(0, 3))
      0:       vals[0] = CFG_W'(16'h8000);
      1:       vals[0] = CFG_W'(16'h7fff);
      2:       vals[0] = '0;
      default: vals[0] = CFG_W'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       vals[1] = '0;
      1:       vals[1] = CFG_W'(15'h7fff);
      2:       vals[1] = CFG_W'($urandom_range(0, 512));
      default: vals[1] = CFG_W'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       vals[2] = '0;
      1:       vals[2] = SUM_MAX;
      2:       vals[2] = CFG_W'($urandom_range(0, 5000));
      default: vals[2] = CFG_W'($urandom);
    endcase
    vals[3] = CFG_W'($urandom);
    vals[0] = junk_above(vals[0], SAMPLE_W);
    vals[1] = junk_above(vals[1], ALLOW_W);
    start = $urandom_range(0, 3);
    for (int i = 0; i < 4; i++) begin
      idx = cfg_idx_e'((start + i) % 4);
      write_reg(idx, vals[idx]);
    end
    gaps_on = ($urandom_range(0, 3) != 0);
    for (int n = 0; n < 120; n++) begin
      if (n % 20 == 0) begin
        case ($urandom_range(0, 2))
          0:       drift = -(int'(sb.allowance) + 96);
          1:       drift = int'(sb.allowance) + 96;
          default: drift = 0;
        endcase
      end
      if ($urandom_range(0, 99) < 3) push_item(KIND_CLEAR, 16'($urandom));
      else push_item(KIND_SAMPLE, pick_sample());
    end
  endtask

  always @(posedge clk_i) begin
    cusum_res_t got;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_input(kind_e'(in_ch.kind), in_ch.sample);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.pos_sum      = out_ch.pos_sum;
        got.neg_sum      = out_ch.neg_sum;
        got.up_fire      = out_ch.up_fire;
        got.down_fire    = out_ch.down_fire;
        got.up_value     = out_ch.up_value;
        got.down_value   = out_ch.down_value;
        got.alarmed      = out_ch.alarmed;
        got.up_count     = out_ch.up_count;
        got.down_count   = out_ch.down_count;
        got.sample_count = out_ch.sample_count;
        sb.check_result(got);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(negedge clk_i);
    forever begin
      gap = idle_len();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_REF_MEAN;
    cfg_data_i   = '0;
    in_ch.valid  = 1'b0;
    in_ch.kind   = KIND_SAMPLE;
    in_ch.sample = '0;
    drift        = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset configuration: alarms both ways, threshold boundary, clear
    push_item(KIND_SAMPLE, 16'sd0);
    push_item(KIND_SAMPLE, 16'sd32767);
    push_item(KIND_SAMPLE, -16'sd32768);
    push_item(KIND_CLEAR, 16'h5a5a);
    push_item(KIND_SAMPLE, 16'sd1408);
    push_item(KIND_SAMPLE, 16'sd129);
    push_item(KIND_CLEAR, 16'hffff);

    // clear-on-alarm after each direction
    write_reg(CFG_CLEAR_ON_ALARM, CFG_W'(1));
    write_reg(CFG_THRESHOLD, CFG_W'(100));
    write_reg(CFG_ALLOWANCE, junk_above('0, ALLOW_W));
    push_item(KIND_SAMPLE, 16'sd1000);
    push_item(KIND_SAMPLE, -16'sd200);
    push_item(KIND_SAMPLE, 16'sd50);

    // both alarms on one sample, sums kept
    write_reg(CFG_CLEAR_ON_ALARM, CFG_W'(0));
    push_item(KIND_SAMPLE, 16'sd1000);
    push_item(KIND_SAMPLE, -16'sd200);
    push_item(KIND_SAMPLE, -16'sd32768);
    push_item(KIND_CLEAR, 16'h0000);

    // extreme mean and an unreachable threshold
    write_reg(CFG_REF_MEAN, junk_above(CFG_W'(16'h8000), SAMPLE_W));
    write_reg(CFG_THRESHOLD, SUM_MAX);
    push_item(KIND_SAMPLE, 16'sd32767);
    push_item(KIND_SAMPLE, -16'sd32768);

    // drive both sums into saturation
    gaps_on = 1'b0;
    run_saturation(-16'sd32768, 16'sd32767);
    gaps_on = 1'b1;
    run_saturation(16'sd32767, -16'sd32768);
    push_item(KIND_CLEAR, 16'h1234);

    repeat (6) run_random_phase();

    drain();
    repeat (4) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
